// ===== rtl/core/zou_he_pressure_boundary_d2q9_macros.svh =====
// Assertion macros for the Zou-He pressure boundary block.
// Used by the port checker; no other dependencies.
`ifndef ZOU_HE_PRESSURE_BOUNDARY_D2Q9_MACROS_SVH
`define ZOU_HE_PRESSURE_BOUNDARY_D2Q9_MACROS_SVH
// same-cycle implication, off during reset
`define ZHP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, off during reset
`define ZHP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
// next-cycle implication, live during reset
`define ZHP_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/zhp_pkg.sv =====
// Package for the Zou-He pressure boundary block: types, widths, side tables.
// No dependencies.
`default_nettype none
package zhp_pkg;

  localparam int PopW        = 32;
  localparam int RhoW        = 31;
  localparam int NumPop      = 9;
  localparam int SumW        = 36;   // weighted sum S, signed
  localparam int MagW        = 35;   // |S|
  localparam int RuW         = 37;   // S - rho, signed
  localparam int NumW        = 38;   // constant-divide numerators
  localparam int QuoW        = 32;   // density quotient bits
  localparam int SatW        = 40;
  localparam int IdxW        = 4;
  localparam int MidDepthDef = 4;
  localparam int OutDepthDef = 2;

  typedef enum logic [1:0] {
    SideNorth = 2'd0,
    SideSouth = 2'd1,
    SideEast  = 2'd2,
    SideWest  = 2'd3
  } side_e;

  typedef logic signed [PopW-1:0] pop_t;
  typedef pop_t [NumPop-1:0] pop_vec_t;

  typedef struct packed {
    side_e             opcode;
    logic [RhoW-1:0]   rho_in;
    pop_t pop_0; pop_t pop_1; pop_t pop_2;
    pop_t pop_3; pop_t pop_4; pop_t pop_5;
    pop_t pop_6; pop_t pop_7; pop_t pop_8;
  } in_t;

  typedef struct packed {
    pop_t out_0; pop_t out_1; pop_t out_2;
    pop_t out_3; pop_t out_4; pop_t out_5;
    pop_t out_6; pop_t out_7; pop_t out_8;
    pop_t vel_x; pop_t vel_y;
  } out_t;

  // classified item between front and back
  typedef struct packed {
    side_e           side;
    logic [RhoW-1:0] rho;
    pop_vec_t        pops;
    logic            s_neg;
    logic            s_zero;
    logic            ovf;     // |S| >= 16*rho: quotient saturates
    logic [MagW-1:0] s_mag;
    logic            a_neg;
    logic            b_neg;
    logic            c_neg;
    logic [NumW-1:0] a_mag;   // |2*ru|
    logic [NumW-1:0] b_mag;   // |3d - ru| / 2
    logic [NumW-1:0] c_mag;   // |-3d - ru| / 2
  } mid_t;

  typedef struct packed {
    logic [IdxW-1:0] ta, tb, k0, k1, k2, u0, u1, u2;
    logic            sg_neg;
  } side_map_t;

  function automatic side_map_t side_map(side_e s);
    side_map_t m;
    case (s)
      SideNorth: m = '{4'd1, 4'd3, 4'd2, 4'd5, 4'd6, 4'd4, 4'd7, 4'd8, 1'b0};
      SideSouth: m = '{4'd1, 4'd3, 4'd4, 4'd7, 4'd8, 4'd2, 4'd5, 4'd6, 1'b1};
      SideEast:  m = '{4'd2, 4'd4, 4'd1, 4'd5, 4'd8, 4'd3, 4'd7, 4'd6, 1'b0};
      SideWest:  m = '{4'd2, 4'd4, 4'd3, 4'd7, 4'd6, 4'd1, 4'd5, 4'd8, 1'b1};
      default:   m = '{4'd1, 4'd3, 4'd2, 4'd5, 4'd6, 4'd4, 4'd7, 4'd8, 1'b0};
    endcase
    return m;
  endfunction

  function automatic pop_vec_t in_pops(in_t x);
    pop_vec_t v;
    v[0] = x.pop_0; v[1] = x.pop_1; v[2] = x.pop_2;
    v[3] = x.pop_3; v[4] = x.pop_4; v[5] = x.pop_5;
    v[6] = x.pop_6; v[7] = x.pop_7; v[8] = x.pop_8;
    return v;
  endfunction

  localparam logic signed [SatW-1:0] SatMax = 40'sh00_7FFF_FFFF;
  localparam logic signed [SatW-1:0] SatMin = 40'shFF_8000_0000;

  function automatic pop_t sat32(logic signed [SatW-1:0] v);
    pop_t r;
    if (v > SatMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = pop_t'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/zhp_fifo.sv =====
// Small register queue, power-of-two depth, first-word fall-through.
// Depends on nothing.
`default_nettype none
module zhp_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  T                mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end
endmodule
`default_nettype wire

// ===== rtl/core/zhp_front.sv =====
// Front end: input register, sums and numerators per boundary side.
// Depends on zhp_pkg.
`default_nettype none
module zhp_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  zhp_pkg::in_t item_i,
  output logic         wr_o,
  output zhp_pkg::mid_t wr_data_o,
  input  logic         wr_full_i
);
  import zhp_pkg::*;

  logic      valid_q;
  in_t       item_q;
  logic      accept;
  side_map_t m;
  pop_vec_t  f;
  logic signed [SumW-1:0] s_sum;
  logic signed [PopW:0]   d_raw, d_val;
  logic signed [RuW-1:0]  ru;
  logic signed [NumW-1:0] d3, na, nb, nc, nb_abs, nc_abs;

  assign full_o = valid_q & wr_full_i;
  assign accept = push_i & ~full_o;
  assign wr_o   = valid_q & ~wr_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (wr_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
  end

  always_comb begin
    m     = side_map(item_q.opcode);
    f     = in_pops(item_q);
    s_sum = SumW'($signed(f[0])) + SumW'($signed(f[m.ta])) + SumW'($signed(f[m.tb]))
          + ((SumW'($signed(f[m.k0])) + SumW'($signed(f[m.k1]))
             + SumW'($signed(f[m.k2]))) <<< 1);
    d_raw = (PopW+1)'($signed(f[m.ta])) - (PopW+1)'($signed(f[m.tb]));
    d_val = m.sg_neg ? -d_raw : d_raw;
    ru    = RuW'(s_sum) - $signed(RuW'(item_q.rho_in));
    d3    = NumW'(d_val) + (NumW'(d_val) <<< 1);
    na    = NumW'(ru) <<< 1;
    nb    = d3 - NumW'(ru);
    nc    = -d3 - NumW'(ru);
    nb_abs = nb[NumW-1] ? -nb : nb;
    nc_abs = nc[NumW-1] ? -nc : nc;

    wr_data_o.side   = item_q.opcode;
    wr_data_o.rho    = item_q.rho_in;
    wr_data_o.pops   = f;
    wr_data_o.s_neg  = s_sum[SumW-1];
    wr_data_o.s_zero = (s_sum == '0);
    wr_data_o.s_mag  = s_sum[SumW-1] ? MagW'(-s_sum) : MagW'(s_sum);
    wr_data_o.ovf    = (wr_data_o.s_mag >= {item_q.rho_in, {(MagW-RhoW){1'b0}}});
    wr_data_o.a_neg  = na[NumW-1];
    wr_data_o.a_mag  = na[NumW-1] ? NumW'(-na) : NumW'(na);
    wr_data_o.b_neg  = nb[NumW-1];
    wr_data_o.b_mag  = NumW'(nb_abs) >> 1;
    wr_data_o.c_neg  = nc[NumW-1];
    wr_data_o.c_mag  = NumW'(nc_abs) >> 1;
  end
endmodule
`default_nettype wire

// ===== rtl/core/zhp_back.sv =====
// Back end: 32-stage radix-2 density divider, shift-add divide by three in
// its first stages, final assembly and result queue. Depends on zhp_pkg, zhp_fifo.
`default_nettype none
module zhp_back #(
  parameter int OutDepth = zhp_pkg::OutDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_empty_i,
  input  zhp_pkg::mid_t mid_data_i,
  output logic          mid_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output zhp_pkg::out_t result_o
);
  import zhp_pkg::*;

  localparam int NStg = QuoW;

  typedef struct packed {
    logic [NumW-1:0] n;   // dividend, later the small remainder
    logic [NumW-1:0] q;   // quotient estimate
  } d3_t;

  typedef struct packed {
    side_e           side;
    logic [RhoW-1:0] rho;
    pop_vec_t        pops;
    logic            s_neg;
    logic            s_zero;
    logic            ovf;
    logic [RhoW-1:0] rem;
    logic [QuoW-1:0] dq;
    logic            a_neg, b_neg, c_neg;
    d3_t             a3, b3, c3;
  } stage_t;

  localparam logic signed [QuoW:0]   QMax = 33'sh0_7FFF_FFFF;
  localparam logic signed [QuoW:0]   QMin = 33'sh1_8000_0000;
  localparam logic signed [QuoW+1:0] OneQ = 34'sd268435456;

  // n/3 as n * 0.0101...b built from shifts, one add per stage; the estimate
  // falls short by at most 15 in remainder, fixed by floor(11*r/32)
  function automatic d3_t d3_step(d3_t x, int k);
    d3_t o;
    o = x;
    case (k)
      0:       o.q = (x.n >> 2) + (x.n >> 4);
      1:       o.q = x.q + (x.q >> 4);
      2:       o.q = x.q + (x.q >> 8);
      3:       o.q = x.q + (x.q >> 16);
      4:       o.q = x.q + (x.q >> 32);
      5:       o.n = x.n - (x.q + (x.q << 1));
      6:       o.q = x.q + ((x.n + (x.n << 1) + (x.n << 3)) >> 5);
      default: o = x;
    endcase
    return o;
  endfunction

  function automatic stage_t step(stage_t s, int k);
    stage_t o;
    logic [QuoW-1:0] t;
    logic ge;
    o     = s;
    t     = {s.rem, s.dq[QuoW-1]};
    ge    = (t >= QuoW'(s.rho));
    o.rem = ge ? RhoW'(t - QuoW'(s.rho)) : RhoW'(t);
    o.dq  = {s.dq[QuoW-2:0], ge};
    o.a3  = d3_step(s.a3, k);
    o.b3  = d3_step(s.b3, k);
    o.c3  = d3_step(s.c3, k);
    return o;
  endfunction

  function automatic out_t finish(stage_t s);
    out_t      o;
    side_map_t m;
    pop_vec_t  g;
    logic signed [QuoW:0]   q;
    logic signed [QuoW+1:0] u;
    logic signed [SatW-1:0] av, bv, cv;
    pop_t      uv;
    m = side_map(s.side);
    g = s.pops;
    if (s.ovf) begin
      q = s.s_neg ? QMin : (s.s_zero ? '0 : QMax);
    end else if (s.s_neg) begin
      q = (s.dq > 32'h8000_0000) ? QMin : -$signed({1'b0, s.dq});
    end else begin
      q = (s.dq > 32'h7FFF_FFFF) ? QMax : $signed({1'b0, s.dq});
    end
    u  = (QuoW+2)'(q) - OneQ;
    uv = sat32(SatW'(u));
    av = $signed(SatW'(s.a3.q));
    bv = $signed(SatW'(s.b3.q));
    cv = $signed(SatW'(s.c3.q));
    if (s.a_neg) av = -av;
    if (s.b_neg) bv = -bv;
    if (s.c_neg) cv = -cv;
    g[m.u0] = sat32(SatW'($signed(s.pops[m.k0])) - av);
    g[m.u1] = sat32(SatW'($signed(s.pops[m.k1])) + bv);
    g[m.u2] = sat32(SatW'($signed(s.pops[m.k2])) + cv);
    o.out_0 = g[0]; o.out_1 = g[1]; o.out_2 = g[2];
    o.out_3 = g[3]; o.out_4 = g[4]; o.out_5 = g[5];
    o.out_6 = g[6]; o.out_7 = g[7]; o.out_8 = g[8];
    if (s.side == SideNorth || s.side == SideSouth) begin
      o.vel_x = '0;
      o.vel_y = uv;
    end else begin
      o.vel_x = uv;
      o.vel_y = '0;
    end
    return o;
  endfunction

  stage_t            init;
  stage_t            st_d [NStg];
  stage_t            st_q [NStg];
  logic [NStg-1:0]   vld_q;
  logic              adv, out_full;
  out_t              fin;

  assign adv       = ~out_full;
  assign mid_pop_o = adv & ~mid_empty_i;
  assign fin       = finish(st_q[NStg-1]);

  always_comb begin
    init.side   = mid_data_i.side;
    init.rho    = mid_data_i.rho;
    init.pops   = mid_data_i.pops;
    init.s_neg  = mid_data_i.s_neg;
    init.s_zero = mid_data_i.s_zero;
    init.ovf    = mid_data_i.ovf;
    init.rem    = mid_data_i.s_mag[MagW-1 -: RhoW];
    init.dq     = {mid_data_i.s_mag[MagW-RhoW-1:0], {(QuoW-MagW+RhoW){1'b0}}};
    init.a_neg  = mid_data_i.a_neg;
    init.b_neg  = mid_data_i.b_neg;
    init.c_neg  = mid_data_i.c_neg;
    init.a3     = '{n: mid_data_i.a_mag, q: '0};
    init.b3     = '{n: mid_data_i.b_mag, q: '0};
    init.c3     = '{n: mid_data_i.c_mag, q: '0};
    st_d[0] = step(init, 0);
    for (int k = 1; k < NStg; k++) st_d[k] = step(st_q[k-1], k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], ~mid_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) st_q <= st_d;
  end

  zhp_fifo #(
    .T     (out_t),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv & vld_q[NStg-1]),
    .wdata_i (fin),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (result_o),
    .empty_o (empty_o)
  );
endmodule
`default_nettype wire

// ===== rtl/core/zou_he_pressure_boundary_d2q9.sv =====
// Top level of the Zou-He pressure boundary for one D2Q9 node.
// Depends on zhp_pkg, zhp_front, zhp_fifo, zhp_back.
//
//  channel   | signals                    | transaction when
//  ----------+----------------------------+------------------------------
//  item in   | push_i, full_o, item_i     | push_i & ~full_o at clk edge
//  result    | pop_i, empty_o, result_o   | pop_i & ~empty_o at clk edge
//
// One item per cycle sustained while results are popped; each item goes
// via the input register, one slot in the middle queue, the 32 stages of the
// radix-2 density divider (one quotient bit per stage), and the result queue.
// Reset (async, active low) empties every queue and pipeline valid bit.
// A stalled result side freezes the back pipeline; the middle queue then
// fills and full_o rises. The input side stalls nothing downstream.
`default_nettype none
module zou_he_pressure_boundary_d2q9 #(
  parameter int MidDepth = zhp_pkg::MidDepthDef,
  parameter int OutDepth = zhp_pkg::OutDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  zhp_pkg::in_t  item_i,
  output logic          empty_o,
  input  logic          pop_i,
  output zhp_pkg::out_t result_o
);
  import zhp_pkg::*;

  // front -> middle queue
  mid_t fr_data;
  logic fr_wr;
  logic mid_full;
  // middle queue -> back
  mid_t mid_head;
  logic mid_empty;
  logic mid_pop;

  // Front: registers the item and works out S, S - rho and the three
  // constant-divide numerators for the side's unknown populations.
  zhp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .item_i    (item_i),
    .wr_o      (fr_wr),
    .wr_data_o (fr_data),
    .wr_full_i (mid_full)
  );

  // Decoupling queue: the front keeps taking items while the back stalls.
  zhp_fifo #(
    .T     (mid_t),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_wr),
    .wdata_i (fr_data),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_head),
    .empty_o (mid_empty)
  );

  // Back: u = S/rho - 1 via the divider pipeline, unknowns rebuilt,
  // everything saturated, then queued for the consumer.
  zhp_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .result_o    (result_o)
  );
endmodule
`default_nettype wire

// ===== rtl/core/zhp_checker.sv =====
// Port-level checker for the Zou-He pressure boundary, bound to the top.
// Depends on zhp_pkg and the macros header.
`default_nettype none
`include "zou_he_pressure_boundary_d2q9_macros.svh"
module zhp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push_i,
  input logic          full_o,
  input logic          empty_o,
  input logic          pop_i,
  input zhp_pkg::out_t result_o
);
  // waiting result stays
  `ZHP_ASSERT_NXT(a_hold_valid, clk_i, rst_ni, !empty_o && !pop_i, !empty_o, "result dropped")
  `ZHP_ASSERT_NXT(a_hold_data, clk_i, rst_ni, !empty_o && !pop_i, $stable(result_o), "result changed")
  // full only rises on the edge of an input transaction
  `ZHP_ASSERT_IMP(a_full_cause, clk_i, rst_ni, $rose(full_o), $past(push_i && !full_o), "full without push")
  // reset leaves both sides idle
  `ZHP_ASSERT_RST(a_rst_idle, clk_i, !rst_ni, empty_o && !full_o, "not idle after reset")
endmodule

bind zou_he_pressure_boundary_d2q9 zhp_checker u_zhp_checker (.*);
`default_nettype wire

// ===== verif/zou_he_pressure_boundary_d2q9_tb.sv =====
// Testbench for the Zou-He pressure boundary block (D2Q9, Q4.28 fixed point).
// Needs zhp_pkg and the RTL of zou_he_pressure_boundary_d2q9; self-checking with
// a built-in boundary predictor and an in-order scoreboard of expected results.
`timescale 1ns / 100ps
`default_nettype none
module zou_he_pressure_boundary_d2q9_tb;
  import zhp_pkg::*;

  // -------------------------------------------------------------------------
  // Boundary predictor: rebuilds the three unknown populations of one node
  // -------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp32(logic signed [79:0] v);
    logic signed [31:0] r;
    if (v > 80'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -80'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic out_t boundary_node(in_t it);
    logic signed [79:0] f [9];
    logic signed [79:0] g [9];
    logic signed [79:0] rho, s, q, u, ru, d;
    int ta, tb, k0, k1, k2, u0, u1, u2;
    bit flip;
    out_t r;
    f[0] = it.pop_0; f[1] = it.pop_1; f[2] = it.pop_2;
    f[3] = it.pop_3; f[4] = it.pop_4; f[5] = it.pop_5;
    f[6] = it.pop_6; f[7] = it.pop_7; f[8] = it.pop_8;
    for (int i = 0; i < 9; i++) g[i] = f[i];
    // tangential pair, known out-going, unknown in-coming per side
    case (it.opcode)
      SideNorth: begin
        ta = 1; tb = 3; k0 = 2; k1 = 5; k2 = 6; u0 = 4; u1 = 7; u2 = 8; flip = 0;
      end
      SideSouth: begin
        ta = 1; tb = 3; k0 = 4; k1 = 7; k2 = 8; u0 = 2; u1 = 5; u2 = 6; flip = 1;
      end
      SideEast: begin
        ta = 2; tb = 4; k0 = 1; k1 = 5; k2 = 8; u0 = 3; u1 = 7; u2 = 6; flip = 0;
      end
      default: begin
        ta = 2; tb = 4; k0 = 3; k1 = 7; k2 = 6; u0 = 1; u1 = 5; u2 = 8; flip = 1;
      end
    endcase
    rho = $signed({49'd0, it.rho_in});
    s = f[0] + f[ta] + f[tb] + 2 * (f[k0] + f[k1] + f[k2]);
    if (rho == 0) begin
      // zero density: quotient pinned to the sign of the sum
      q = (s > 0) ? 80'sd2147483647 : ((s < 0) ? -80'sd2147483648 : 80'sd0);
    end else begin
      q = (s * 80'sd268435456) / rho;  // SV division truncates toward zero
    end
    u = clamp32(clamp32(q) - 80'sd268435456);
    ru = s - rho;
    d = f[ta] - f[tb];
    if (flip) d = -d;
    g[u0] = f[k0] - (2 * ru) / 3;
    g[u1] = f[k1] + (3 * d - ru) / 6;
    g[u2] = f[k2] + (-3 * d - ru) / 6;
    r.out_0 = clamp32(g[0]); r.out_1 = clamp32(g[1]); r.out_2 = clamp32(g[2]);
    r.out_3 = clamp32(g[3]); r.out_4 = clamp32(g[4]); r.out_5 = clamp32(g[5]);
    r.out_6 = clamp32(g[6]); r.out_7 = clamp32(g[7]); r.out_8 = clamp32(g[8]);
    if (it.opcode == SideNorth || it.opcode == SideSouth) begin
      r.vel_x = '0; r.vel_y = clamp32(u);
    end else begin
      r.vel_x = clamp32(u); r.vel_y = '0;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Scoreboard: expected node results in arrival order
  // -------------------------------------------------------------------------
  class node_scoreboard;
    out_t pending_q[$];
    int   errors;
    int   checked;

    function void note_item(in_t it);
      pending_q.push_back(boundary_node(it));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (got.out_0 !== exp_r.out_0) report("out_0", exp_r.out_0, got.out_0);
      if (got.out_1 !== exp_r.out_1) report("out_1", exp_r.out_1, got.out_1);
      if (got.out_2 !== exp_r.out_2) report("out_2", exp_r.out_2, got.out_2);
      if (got.out_3 !== exp_r.out_3) report("out_3", exp_r.out_3, got.out_3);
      if (got.out_4 !== exp_r.out_4) report("out_4", exp_r.out_4, got.out_4);
      if (got.out_5 !== exp_r.out_5) report("out_5", exp_r.out_5, got.out_5);
      if (got.out_6 !== exp_r.out_6) report("out_6", exp_r.out_6, got.out_6);
      if (got.out_7 !== exp_r.out_7) report("out_7", exp_r.out_7, got.out_7);
      if (got.out_8 !== exp_r.out_8) report("out_8", exp_r.out_8, got.out_8);
      if (got.vel_x !== exp_r.vel_x) report("vel_x", exp_r.vel_x, got.vel_x);
      if (got.vel_y !== exp_r.vel_y) report("vel_y", exp_r.vel_y, got.vel_y);
    endfunction

    function void report(string fld, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, fld, e, a);
      errors++;
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, DUT
  // -------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  logic push_i;
  logic full_o;
  in_t  item_i;
  logic empty_o;
  logic pop_i;
  out_t result_o;

  node_scoreboard sb;

  // idling percentages, changed per phase by the stimulus process
  int send_idle_pct;
  int recv_stall_pct;
  bit recv_hold;        // long receiver hold-off, set by its own process
  bit hold_arm;         // starts the hold-off countdown

  zou_he_pressure_boundary_d2q9 dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .item_i   (item_i),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  // population values: mostly moderate lattice values, sometimes extremes
  function automatic pop_t pick_pop();
    pop_t p;
    case ($urandom_range(0, 9))
      0:       p = 32'sh7FFF_FFFF;
      1:       p = 32'sh8000_0000;
      2:       p = $urandom();
      3:       p = '0;
      default: p = $signed($urandom_range(0, 32'h2000_0000)) - 32'sh0400_0000;
    endcase
    return p;
  endfunction

  function automatic logic [30:0] pick_rho();
    logic [30:0] r;
    case ($urandom_range(0, 7))
      0:       r = 31'd1;
      1:       r = 31'h7FFF_FFFF;
      2:       r = 31'($urandom_range(1, 32'h7FFF_FFFF));
      default: r = 31'($urandom_range(32'h0800_0000, 32'h2000_0000));  // near 1.0
    endcase
    return r;
  endfunction

  function automatic in_t rand_item();
    in_t it;
    it.opcode = side_e'($urandom_range(0, 3));
    it.rho_in = pick_rho();
    it.pop_0 = pick_pop(); it.pop_1 = pick_pop(); it.pop_2 = pick_pop();
    it.pop_3 = pick_pop(); it.pop_4 = pick_pop(); it.pop_5 = pick_pop();
    it.pop_6 = pick_pop(); it.pop_7 = pick_pop(); it.pop_8 = pick_pop();
    return it;
  endfunction

  function automatic in_t flat_item(side_e sd, logic [30:0] rho, pop_t v);
    in_t it;
    it.opcode = sd;
    it.rho_in = rho;
    it.pop_0 = v; it.pop_1 = v; it.pop_2 = v; it.pop_3 = v; it.pop_4 = v;
    it.pop_5 = v; it.pop_6 = v; it.pop_7 = v; it.pop_8 = v;
    return it;
  endfunction

  // Offer one item, idling first at random; returns once it is accepted.
  // push_i stays high across back-to-back items (no lower/raise in one step).
  task automatic send_item(in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full_o);
    sb.note_item(it);
  endtask

  task automatic idle_sender();
    push_i <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // Result side: pop at random, sampled at the clock edge
  // -------------------------------------------------------------------------
  initial begin
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_result(result_o);
      pop_i <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps pushing
  initial begin
    recv_hold = 1'b0;
    wait (hold_arm);
    repeat (100) @(posedge clk_i);
    recv_hold <= 1'b1;
    repeat (200) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // Main stimulus
  // -------------------------------------------------------------------------
  initial begin
    in_t it;
    sb = new();
    push_i = 1'b0;
    item_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_arm = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: every side at rest density, extremes, overflow cases
    for (int s = 0; s < 4; s++) begin
      send_item(flat_item(side_e'(s), 31'h1000_0000, 32'sh01C7_1C71));
      send_item(flat_item(side_e'(s), 31'd1, 32'sh7FFF_FFFF));        // quotient saturates
      send_item(flat_item(side_e'(s), 31'h7FFF_FFFF, 32'sh8000_0000));
      send_item(flat_item(side_e'(s), 31'h7FFF_FFFF, 32'sh0000_0000)); // zero sum
      send_item(flat_item(side_e'(s), 31'd1, 32'shFFFF_FFFF));        // negative sum, tiny rho
    end
    it = flat_item(SideEast, 31'h1000_0000, 32'sh0100_0000);
    it.pop_2 = 32'sh7FFF_FFFF; it.pop_4 = 32'sh8000_0000;             // large tangential diff
    send_item(it);
    it.opcode = SideWest;
    send_item(it);
    it = flat_item(SideNorth, 31'h5555_5555, 32'shAAAA_AAAA);
    it.pop_1 = 32'sh5555_5555;
    send_item(it);
    wait_drained();   // sender pauses until all results are in

    // random phases with varied idling; the long hold-off lands in the first
    hold_arm = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int n = 0; n < 220; n++) send_item(rand_item());
    end
    idle_sender();

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Covered four sides, density and population extremes, %0d results checked",
             sb.checked);
    $display("under idle, stalled and back-pressured traffic, %0d errors", sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== zou_he_pressure_boundary_d2q9.f =====
+incdir+rtl/core
rtl/core/zhp_pkg.sv
rtl/core/zhp_fifo.sv
rtl/core/zhp_front.sv
rtl/core/zhp_back.sv
rtl/core/zou_he_pressure_boundary_d2q9.sv
rtl/core/zhp_checker.sv
verif/zou_he_pressure_boundary_d2q9_tb.sv
